[hw/rtl/page_owner_refcount_table_core_assert.svh]
// Assertion helpers for the page ownership table.
`ifndef PAGE_OWNER_REFCOUNT_TABLE_CORE_ASSERT_SVH
`define PAGE_OWNER_REFCOUNT_TABLE_CORE_ASSERT_SVH

// same-cycle implication
`define POR_ASSERT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define POR_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/por_pkg.sv]
`default_nettype none

package por_pkg;

  localparam int PAGE_COUNT_DEF    = 32768;
  localparam int ACCOUNT_SLOTS_DEF = 64;
  localparam int REF_LIMIT_DEF     = 255;

  localparam int FUNC_W  = 3;
  localparam int INDEX_W = 15;
  localparam int SLOT_W  = 6;
  localparam int GEN_W   = 64;
  localparam int STAT_W  = 2;
  localparam int REFS_W  = 8;
  localparam int COUNT_W = 16;

  localparam logic [FUNC_W-1:0] FN_TRACK           = 3'd0;
  localparam logic [FUNC_W-1:0] FN_RETAIN          = 3'd1;
  localparam logic [FUNC_W-1:0] FN_QUERY           = 3'd2;
  localparam logic [FUNC_W-1:0] FN_RELEASE         = 3'd3;
  localparam logic [FUNC_W-1:0] FN_CHECKED_RELEASE = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_REJECT = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FAULT  = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [INDEX_W-1:0] page_index;
    logic [SLOT_W-1:0]  account_slot;
    logic [GEN_W-1:0]   account_generation;
    logic               pool_class;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              exclusive;
    logic              freed;
    logic              freed_class;
    logic [SLOT_W-1:0] released_slot;
    logic [GEN_W-1:0]  released_generation;
    logic              account_emptied;
  } rsp_t;

  // tracked implies refs != 0 and owner is a valid slot
  typedef struct packed {
    logic              tracked;
    logic              cls;
    logic [SLOT_W-1:0] owner;
    logic [REFS_W-1:0] refs;
  } page_entry_t;

  typedef struct packed {
    logic [GEN_W-1:0]   gen;
    logic [COUNT_W-1:0] cnt;
  } slot_entry_t;

  typedef struct packed {
    logic              need_owner;
    logic              page_we;
    page_entry_t       page_wdata;
    logic              slot_we;
    logic [SLOT_W-1:0] slot_waddr;
    slot_entry_t       slot_wdata;
    rsp_t              result;
  } cmd_t;

endpackage

`default_nettype wire

[hw/rtl/por_req_if.sv]
`default_nettype none

interface por_req_if;
  import por_pkg::*;

  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [INDEX_W-1:0] page_index;
  logic [SLOT_W-1:0]  account_slot;
  logic [GEN_W-1:0]   account_generation;
  logic               pool_class;

  modport source (
    output valid, func, page_index, account_slot, account_generation, pool_class,
    input  ready
  );

  modport sink (
    input  valid, func, page_index, account_slot, account_generation, pool_class,
    output ready
  );
endinterface

`default_nettype wire

[hw/rtl/por_rsp_if.sv]
`default_nettype none

interface por_rsp_if;
  import por_pkg::*;

  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic              exclusive;
  logic              freed;
  logic              freed_class;
  logic [SLOT_W-1:0] released_slot;
  logic [GEN_W-1:0]  released_generation;
  logic              account_emptied;

  modport source (
    output valid, status, exclusive, freed, freed_class, released_slot,
           released_generation, account_emptied,
    input  ready
  );

  modport sink (
    input  valid, status, exclusive, freed, freed_class, released_slot,
           released_generation, account_emptied,
    output ready
  );
endinterface

`default_nettype wire

[hw/rtl/por_ram.sv]
`default_nettype none

module por_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/por_exec.sv]
`default_nettype none

module por_exec #(
  parameter int PAGE_COUNT    = por_pkg::PAGE_COUNT_DEF,
  parameter int ACCOUNT_SLOTS = por_pkg::ACCOUNT_SLOTS_DEF,
  parameter int REF_LIMIT     = por_pkg::REF_LIMIT_DEF
) (
  input  por_pkg::req_t        req,
  input  por_pkg::page_entry_t pe,
  input  por_pkg::slot_entry_t se,
  output por_pkg::cmd_t        cmd
);
  import por_pkg::*;

  logic idx_oor;
  logic slot_oor;
  logic match;
  logic [COUNT_W-1:0] cnt_dec;

  assign idx_oor  = 32'(req.page_index) >= 32'(PAGE_COUNT);
  assign slot_oor = 32'(req.account_slot) >= 32'(ACCOUNT_SLOTS);
  assign match    = pe.tracked && (pe.owner == req.account_slot) &&
                    (se.gen == req.account_generation) && (pe.cls == req.pool_class);
  assign cnt_dec  = se.cnt - 1'b1;

  always_comb begin
    cmd = '0;
    cmd.result.status = STAT_OK;
    cmd.need_owner = !idx_oor && (req.func == FN_RELEASE) && pe.tracked &&
                     (pe.refs == 8'd1);
    if (idx_oor) begin
      cmd.result.status = STAT_FAULT;
    end else begin
      case (req.func)
        FN_TRACK: begin
          if (slot_oor || (req.account_generation == '0) || pe.tracked ||
              (pe.refs != '0) || (se.cnt == '1) ||
              ((se.cnt != '0) && (se.gen != req.account_generation))) begin
            cmd.result.status = STAT_FAULT;
          end else begin
            cmd.slot_we          = 1'b1;
            cmd.slot_waddr       = req.account_slot;
            cmd.slot_wdata.gen   = (se.cnt == '0) ? req.account_generation : se.gen;
            cmd.slot_wdata.cnt   = se.cnt + 1'b1;
            cmd.page_we          = 1'b1;
            cmd.page_wdata       = '{tracked: 1'b1, cls: req.pool_class,
                                     owner: req.account_slot, refs: 8'd1};
          end
        end
        FN_RETAIN: begin
          if (!pe.tracked || (pe.refs == '0) || (pe.refs >= 8'(REF_LIMIT))) begin
            cmd.result.status = STAT_REJECT;
          end else begin
            cmd.page_we         = 1'b1;
            cmd.page_wdata      = pe;
            cmd.page_wdata.refs = pe.refs + 1'b1;
          end
        end
        FN_QUERY: begin
          cmd.result.exclusive = pe.tracked && (pe.refs == 8'd1) && match;
        end
        FN_RELEASE, FN_CHECKED_RELEASE: begin
          if (!pe.tracked || (pe.refs == '0)) begin
            cmd.result.status = STAT_REJECT;
          end else if ((req.func == FN_CHECKED_RELEASE) && !match) begin
            cmd.result.status = STAT_REJECT;
          end else if (pe.refs > 8'd1) begin
            cmd.page_we         = 1'b1;
            cmd.page_wdata      = pe;
            cmd.page_wdata.refs = pe.refs - 1'b1;
          end else if ((se.gen == '0) || (se.cnt == '0)) begin
            // se holds the owner's slot entry here
            cmd.result.status = STAT_FAULT;
          end else begin
            cmd.result.freed               = 1'b1;
            cmd.result.freed_class         = pe.cls;
            cmd.result.released_slot       = pe.owner;
            cmd.result.released_generation = se.gen;
            cmd.result.account_emptied     = (cnt_dec == '0);
            cmd.page_we                    = 1'b1;
            cmd.page_wdata                 = '0;
            cmd.slot_we                    = 1'b1;
            cmd.slot_waddr                 = pe.owner;
            cmd.slot_wdata.gen             = (cnt_dec == '0) ? '0 : se.gen;
            cmd.slot_wdata.cnt             = cnt_dec;
          end
        end
        default: begin
          cmd.result.status = STAT_FAULT;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[hw/rtl/page_owner_refcount_table_core.sv]
// Flow: an accepted beat reads the page and slot memories, and its result beat is
//   registered from S_EXEC; an unchecked release of a page's last reference goes
//   through S_OWNER instead, for a second read of the owner slot.
// Throughput: one operation at a time, set by the read-modify-write of the page and
//   slot memories; a result waits while the previous result beat is held by rsp.ready.
// Reset: a clearing pass zeroes both memories with req.ready low.
`default_nettype none

`include "page_owner_refcount_table_core_assert.svh"

module page_owner_refcount_table_core #(
  parameter int PAGE_COUNT    = por_pkg::PAGE_COUNT_DEF,
  parameter int ACCOUNT_SLOTS = por_pkg::ACCOUNT_SLOTS_DEF,
  parameter int REF_LIMIT     = por_pkg::REF_LIMIT_DEF
) (
  input wire logic clk,
  input wire logic rst,
  por_req_if.sink  req,
  por_rsp_if.source rsp
);
  import por_pkg::*;

  localparam int PA_W      = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int SA_W      = (ACCOUNT_SLOTS > 1) ? $clog2(ACCOUNT_SLOTS) : 1;
  localparam int MAX_DEPTH = (PAGE_COUNT > ACCOUNT_SLOTS) ? PAGE_COUNT : ACCOUNT_SLOTS;
  localparam int CLR_W     = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;
  localparam logic [1:0] S_OWNER = 2'd3;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [CLR_W-1:0] clr_addr;
  logic             clr_last;
  req_t             req_q;
  logic             accept;
  logic             out_valid;
  logic             out_free;
  logic             commit;
  rsp_t             out_q;
  cmd_t             cmd;

  page_entry_t      page_rdata;
  slot_entry_t      slot_rdata;
  logic             page_we;
  logic [PA_W-1:0]  page_waddr;
  page_entry_t      page_wdata;
  logic             slot_we;
  logic [SA_W-1:0]  slot_waddr;
  slot_entry_t      slot_wdata;
  logic             slot_re;
  logic [SA_W-1:0]  slot_raddr;

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign out_free  = !out_valid || rsp.ready;
  assign clr_last  = (clr_addr == CLR_W'(MAX_DEPTH - 1));
  assign commit    = ((state == S_EXEC) && !cmd.need_owner && out_free) ||
                     ((state == S_OWNER) && out_free);

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (clr_last) state_next = S_IDLE;
      S_IDLE:  if (accept) state_next = S_EXEC;
      S_EXEC: begin
        if (cmd.need_owner) begin
          state_next = S_OWNER;
        end else if (out_free) begin
          state_next = S_IDLE;
        end
      end
      S_OWNER: if (out_free) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (commit) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= '{func: req.func, page_index: req.page_index,
                 account_slot: req.account_slot,
                 account_generation: req.account_generation,
                 pool_class: req.pool_class};
    end
    if (commit) begin
      out_q <= cmd.result;
    end
  end

  always_comb begin
    if (state == S_CLEAR) begin
      page_we    = {1'b0, clr_addr} < (CLR_W + 1)'(PAGE_COUNT);
      page_waddr = PA_W'(clr_addr);
      page_wdata = '0;
      slot_we    = {1'b0, clr_addr} < (CLR_W + 1)'(ACCOUNT_SLOTS);
      slot_waddr = SA_W'(clr_addr);
      slot_wdata = '0;
    end else begin
      page_we    = commit && cmd.page_we;
      page_waddr = PA_W'(req_q.page_index);
      page_wdata = cmd.page_wdata;
      slot_we    = commit && cmd.slot_we;
      slot_waddr = SA_W'(cmd.slot_waddr);
      slot_wdata = cmd.slot_wdata;
    end
  end

  assign slot_re    = accept || ((state == S_EXEC) && cmd.need_owner);
  assign slot_raddr = accept ? SA_W'(req.account_slot) : SA_W'(page_rdata.owner);

  por_ram #(
    .WIDTH ($bits(page_entry_t)),
    .DEPTH (PAGE_COUNT)
  ) u_page_ram (
    .clk   (clk),
    .we    (page_we),
    .waddr (page_waddr),
    .wdata (page_wdata),
    .re    (accept),
    .raddr (PA_W'(req.page_index)),
    .rdata (page_rdata)
  );

  por_ram #(
    .WIDTH ($bits(slot_entry_t)),
    .DEPTH (ACCOUNT_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .re    (slot_re),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  por_exec #(
    .PAGE_COUNT    (PAGE_COUNT),
    .ACCOUNT_SLOTS (ACCOUNT_SLOTS),
    .REF_LIMIT     (REF_LIMIT)
  ) u_exec (
    .req (req_q),
    .pe  (page_rdata),
    .se  (slot_rdata),
    .cmd (cmd)
  );

  assign rsp.valid               = out_valid;
  assign rsp.status              = out_q.status;
  assign rsp.exclusive           = out_q.exclusive;
  assign rsp.freed               = out_q.freed;
  assign rsp.freed_class         = out_q.freed_class;
  assign rsp.released_slot       = out_q.released_slot;
  assign rsp.released_generation = out_q.released_generation;
  assign rsp.account_emptied     = out_q.account_emptied;

  `POR_ASSERT_NXT(a_one_in_flight, clk, rst, accept, !req.ready,
                  "second beat accepted while busy")
  `POR_ASSERT(a_owner_path, clk, rst, state == S_OWNER,
              $past(state) == S_EXEC || $past(state) == S_OWNER,
              "owner read not entered from exec")
  `POR_ASSERT(a_not_freed_clean, clk, rst, rsp.valid && !rsp.freed,
              !rsp.account_emptied && !rsp.freed_class && rsp.released_slot == '0 &&
              rsp.released_generation == '0,
              "release fields set without free")
  `POR_ASSERT(a_emptied_ok, clk, rst, rsp.valid && rsp.account_emptied,
              rsp.freed && rsp.status == STAT_OK,
              "account emptied without a freed page")
  `POR_ASSERT(a_no_rsp_in_clear, clk, rst, state == S_CLEAR, !rsp.valid && !req.ready,
              "activity during clearing pass")

endmodule

`default_nettype wire
